@@ design/afps_pkg.sv @@
// Package for the azimuthal flow particle step block.
// Holds the payload structs, register widths, reset values and register indexes.
// No dependencies.
package afps_pkg;

    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int FRAME_W = 17;
    localparam int AZ_W    = 4;
    localparam int SPEED_W = 19;
    localparam int PULL_W  = 17;
    localparam int RDIST_W = 19;

    localparam logic [FRAME_W-1:0] FRAME_RST = 17'd1092;
    localparam logic [AZ_W-1:0]    AZ_RST    = 4'd0;
    localparam logic [SPEED_W-1:0] SPEED_RST = 19'd52429;
    localparam logic [PULL_W-1:0]  PULL_RST  = 17'd5243;
    localparam logic [RDIST_W-1:0] RDIST_RST = 19'd98304;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_STEP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AZIMUTHAL_NUMBER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULL_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_DISTANCE   = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] home_x;
        logic signed [COORD_W-1:0] home_y;
        logic signed [COORD_W-1:0] home_z;
    } afps_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] new_x;
        logic signed [COORD_W-1:0] new_y;
        logic signed [COORD_W-1:0] new_z;
        logic                      respawned;
    } afps_out_t;

endpackage

@@ design/afps_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband vector alongside; no package dependency.
module afps_sqrt_pipe #(
    parameter int IN_W = 63,
    parameter int SIDE_W = 8,
    localparam int ROOT_W = (IN_W + 1) / 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_val,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);
    localparam int STEPS = ROOT_W;
    localparam int AW    = 2 * STEPS;

    logic [AW-1:0]     val_reg  [STEPS];
    logic [AW-1:0]     res_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic              vld_reg  [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam int BITPOS = 2 * (STEPS - 1 - g);
        logic [AW-1:0]     val_in, res_in, val_next, res_next, sum;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;

        if (g == 0) begin : g_first
            assign val_in  = AW'(in_val);
            assign res_in  = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_rest
            assign val_in  = val_reg[g-1];
            assign res_in  = res_reg[g-1];
            assign side_in = side_reg[g-1];
            assign vld_in  = vld_reg[g-1];
        end

        always_comb begin
            sum = res_in + (AW'(1) << BITPOS);
            if (val_in >= sum) begin
                val_next = val_in - sum;
                res_next = (res_in >> 1) + (AW'(1) << BITPOS);
            end else begin
                val_next = val_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (adv) begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                val_reg[g]  <= val_next;
                res_reg[g]  <= res_next;
                side_reg[g] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_root  = res_reg[STEPS-1][ROOT_W-1:0];
    assign out_side  = side_reg[STEPS-1];

endmodule

@@ design/afps_div_pipe.sv @@
// Pipelined restoring divider over several lanes, one quotient bit per stage.
// Carries a sideband vector alongside; no package dependency.
module afps_div_pipe #(
    parameter int LANES = 3,
    parameter int NUM_W = 40,
    parameter int DEN_W = 34,
    parameter int Q_W = 25,
    parameter int SIDE_W = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUM_W-1:0] in_num,
    input  logic [LANES-1:0][DEN_W-1:0] in_den,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][Q_W-1:0]   out_quo,
    output logic [SIDE_W-1:0]           out_side
);
    localparam int REM_W = DEN_W + Q_W;

    logic [LANES-1:0][REM_W-1:0] rem_reg  [Q_W];
    logic [LANES-1:0][DEN_W-1:0] den_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0]   quo_reg  [Q_W];
    logic [SIDE_W-1:0]           side_reg [Q_W];
    logic                        vld_reg  [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_step
        localparam int BITPOS = Q_W - 1 - g;
        logic [LANES-1:0][REM_W-1:0] rem_in, rem_next;
        logic [LANES-1:0][DEN_W-1:0] den_in;
        logic [LANES-1:0][Q_W-1:0]   quo_in, quo_next;
        logic [SIDE_W-1:0]           side_in;
        logic                        vld_in;

        if (g == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = REM_W'(in_num[l]);
                end
            end
            assign den_in  = in_den;
            assign quo_in  = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign den_in  = den_reg[g-1];
            assign quo_in  = quo_reg[g-1];
            assign side_in = side_reg[g-1];
            assign vld_in  = vld_reg[g-1];
        end

        always_comb begin
            logic [REM_W-1:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = REM_W'(den_in[l]) << BITPOS;
                if (rem_in[l] >= trial) begin
                    rem_next[l] = rem_in[l] - trial;
                    quo_next[l] = quo_in[l] | (Q_W'(1) << BITPOS);
                end else begin
                    rem_next[l] = rem_in[l];
                    quo_next[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (adv) begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[g]  <= rem_next;
                den_reg[g]  <= den_in;
                quo_reg[g]  <= quo_next;
                side_reg[g] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

@@ design/azimuthal_flow_particle_step.sv @@
// Pipeline of 69 register stages for FRAC_BITS 8..24 (32 root, 25 divider, 12 arithmetic
// and register); throughput one request per cycle while the output register is not stalled.
// The whole pipeline advances when the output register is empty or being taken.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// Top level of the azimuthal flow particle step; uses afps_pkg, afps_sqrt_pipe,
// afps_div_pipe.
module azimuthal_flow_particle_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  afps_pkg::afps_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output afps_pkg::afps_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [afps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [afps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import afps_pkg::*;

    localparam int FB      = FRAC_BITS;
    localparam int CW      = COORD_W;
    localparam int RW      = (CW < 31) ? CW : 31;
    localparam int XS      = (CW > 31) ? CW - 31 : 0;
    localparam int SHIFT_W = (XS > 0) ? $clog2(XS + 1) : 1;
    localparam int SQ_W    = 2 * RW + 1;
    localparam int ROOT_W  = (SQ_W + 1) / 2;
    localparam int RHO_W   = ROOT_W + XS;
    localparam int DEN_W   = ((RHO_W > FB) ? RHO_W : FB) + 1;
    localparam int MK_W    = AZ_W + SPEED_W;
    localparam int KNUM_W  = MK_W + FB;
    localparam int UNUM_W  = RW + FB;
    localparam int DNUM_W  = (KNUM_W > UNUM_W) ? KNUM_W : UNUM_W;
    localparam int K_Q     = AZ_W + SPEED_W + 2;
    localparam int DIV_Q   = (K_Q > FB + 1) ? K_Q : FB + 1;
    localparam int K_W     = DIV_Q + 1;
    localparam int U_W     = FB + 2;
    localparam int VP_W    = U_W + K_W;
    localparam int VS_W    = VP_W - FB;
    localparam int PD_W    = CW + 1;
    localparam int PP_W    = PD_W + PULL_W + 1;
    localparam int PT_W    = PP_W - FB;
    localparam int V_W     = ((VS_W > PT_W) ? VS_W : PT_W) + 1;
    localparam int DP_W    = V_W + FRAME_W + 1;
    localparam int DL_W    = DP_W - FB;
    localparam int NP_W    = ((CW > DL_W) ? CW : DL_W) + 1;
    localparam int D_W     = NP_W + 1;
    localparam int SQD_W   = 2 * RDIST_W;
    localparam int SUM_W   = SQD_W + 2;

    localparam logic [RHO_W-1:0] MIN_RHO = RHO_W'((5 * (1 << FB) + 50) / 100);
    localparam logic [DEN_W-1:0] QUARTER = DEN_W'((1 << FB) / 4);
    localparam logic signed [NP_W-1:0] NP_MAX = {{(NP_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [NP_W-1:0] NP_MIN = {{(NP_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

    typedef struct packed {
        afps_in_t                  pos;
        logic [2:0][PT_W-1:0]      pt;
        logic [RW-1:0]             axs;
        logic [RW-1:0]             ays;
        logic [SHIFT_W-1:0]        sh;
        logic                      swirl;
        logic                      xneg;
        logic                      yneg;
    } sq_side_t;

    typedef struct packed {
        afps_in_t                  pos;
        logic [2:0][PT_W-1:0]      pt;
        logic                      swirl;
        logic                      xneg;
        logic                      yneg;
    } dv_side_t;

    localparam int SQ_SIDE_W = $bits(sq_side_t);
    localparam int DV_SIDE_W = $bits(dv_side_t);

    // configuration registers
    logic [FRAME_W-1:0]        frame_step_reg;
    logic signed [AZ_W-1:0]    az_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic [PULL_W-1:0]         pull_reg;
    logic [RDIST_W-1:0]        rdist_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_step_reg <= FRAME_RST;
            az_reg         <= AZ_RST;
            speed_reg      <= SPEED_RST;
            pull_reg       <= PULL_RST;
            rdist_reg      <= RDIST_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_STEP:       frame_step_reg <= cfg_data[FRAME_W-1:0];
                REG_AZIMUTHAL_NUMBER: az_reg         <= cfg_data[AZ_W-1:0];
                REG_SPEED_GAIN:       speed_reg      <= cfg_data[SPEED_W-1:0];
                REG_PULL_GAIN:        pull_reg       <= cfg_data[PULL_W-1:0];
                REG_RESET_DISTANCE:   rdist_reg      <= cfg_data[RDIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic m_valid_reg;
    afps_out_t m_data_reg;
    logic adv;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // stage 1: input register
    afps_in_t in_reg;
    logic     vld1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg <= s_data;
        end
    end

    // stage 2: magnitudes, range shift, offset to home
    logic signed [CW-1:0]  p1 [3];
    logic signed [CW-1:0]  h1 [3];
    logic [CW-1:0]         ax_abs, ay_abs, axy_or, ax_sh, ay_sh;
    logic [SHIFT_W-1:0]    sh_next;
    logic signed [PD_W-1:0] diff_next [3];

    assign p1[0] = in_reg.pos_x;
    assign p1[1] = in_reg.pos_y;
    assign p1[2] = in_reg.pos_z;
    assign h1[0] = in_reg.home_x;
    assign h1[1] = in_reg.home_y;
    assign h1[2] = in_reg.home_z;

    always_comb begin
        ax_abs = in_reg.pos_x[CW-1] ? (~in_reg.pos_x + 1'b1) : in_reg.pos_x;
        ay_abs = in_reg.pos_y[CW-1] ? (~in_reg.pos_y + 1'b1) : in_reg.pos_y;
        axy_or = ax_abs | ay_abs;
        sh_next = '0;
        for (int i = 0; i < CW; i++) begin
            if (i >= 31 && axy_or[i]) begin
                sh_next = SHIFT_W'(i - 30);
            end
        end
        ax_sh = ax_abs >> sh_next;
        ay_sh = ay_abs >> sh_next;
        for (int i = 0; i < 3; i++) begin
            diff_next[i] = PD_W'(h1[i]) - PD_W'(p1[i]);
        end
    end

    afps_in_t               pos2_reg;
    logic [RW-1:0]          axs2_reg, ays2_reg;
    logic [SHIFT_W-1:0]     sh2_reg;
    logic signed [PD_W-1:0] diff2_reg [3];
    logic                   swirl2_reg, xneg2_reg, yneg2_reg, vld2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (adv) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pos2_reg   <= in_reg;
            axs2_reg   <= RW'(ax_sh);
            ays2_reg   <= RW'(ay_sh);
            sh2_reg    <= sh_next;
            diff2_reg  <= diff_next;
            swirl2_reg <= (axy_or != '0) && (az_reg != '0);
            xneg2_reg  <= in_reg.pos_x[CW-1];
            yneg2_reg  <= in_reg.pos_y[CW-1];
        end
    end

    // stage 3: squares and pull products
    logic [2*RW-1:0]        sqx3_reg, sqy3_reg;
    logic signed [PP_W-1:0] pp3_reg [3];
    afps_in_t               pos3_reg;
    logic [RW-1:0]          axs3_reg, ays3_reg;
    logic [SHIFT_W-1:0]     sh3_reg;
    logic                   swirl3_reg, xneg3_reg, yneg3_reg, vld3_reg;
    logic signed [PULL_W:0] pull_s;

    assign pull_s = $signed({1'b0, pull_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx3_reg <= (2*RW)'(axs2_reg) * (2*RW)'(axs2_reg);
            sqy3_reg <= (2*RW)'(ays2_reg) * (2*RW)'(ays2_reg);
            for (int i = 0; i < 3; i++) begin
                pp3_reg[i] <= PP_W'(diff2_reg[i]) * PP_W'(pull_s);
            end
            pos3_reg   <= pos2_reg;
            axs3_reg   <= axs2_reg;
            ays3_reg   <= ays2_reg;
            sh3_reg    <= sh2_reg;
            swirl3_reg <= swirl2_reg;
            xneg3_reg  <= xneg2_reg;
            yneg3_reg  <= yneg2_reg;
        end
    end

    // stage 4: sum of squares, truncate pull terms
    sq_side_t          side4_next;
    logic signed [PP_W-1:0] pp_adj;

    always_comb begin
        side4_next.pos   = pos3_reg;
        side4_next.axs   = axs3_reg;
        side4_next.ays   = ays3_reg;
        side4_next.sh    = sh3_reg;
        side4_next.swirl = swirl3_reg;
        side4_next.xneg  = xneg3_reg;
        side4_next.yneg  = yneg3_reg;
        pp_adj = '0;
        for (int i = 0; i < 3; i++) begin
            pp_adj = pp3_reg[i] + $signed({{(PP_W-FB){1'b0}}, {FB{pp3_reg[i][PP_W-1]}}});
            side4_next.pt[i] = PT_W'(pp_adj >>> FB);
        end
    end

    logic [SQ_W-1:0] sum4_reg;
    sq_side_t        side4_reg;
    logic            vld4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
        end else if (adv) begin
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum4_reg  <= SQ_W'(sqx3_reg) + SQ_W'(sqy3_reg);
            side4_reg <= side4_next;
        end
    end

    // square root
    logic                 sq_valid;
    logic [ROOT_W-1:0]    sq_root;
    logic [SQ_SIDE_W-1:0] sq_side_raw;
    sq_side_t             sqo;

    afps_sqrt_pipe #(
        .IN_W   (SQ_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vld4_reg),
        .in_val    (sum4_reg),
        .in_side   (side4_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side_raw)
    );

    assign sqo = sq_side_t'(sq_side_raw);

    // stage 5: radius clamp, divider operands
    logic [RHO_W-1:0]  rho, rhoc;
    logic [AZ_W-1:0]   m_abs;
    logic [MK_W-1:0]   mk;
    logic [2:0][DNUM_W-1:0] dnum_next;
    logic [2:0][DEN_W-1:0]  dden_next;
    dv_side_t          dv_side_next;

    always_comb begin
        rho  = RHO_W'(sq_root) << sqo.sh;
        rhoc = (rho < MIN_RHO) ? MIN_RHO : rho;
        m_abs = az_reg[AZ_W-1] ? (~az_reg + 1'b1) : az_reg;
        mk = MK_W'(m_abs) * MK_W'(speed_reg);
        dnum_next[0] = DNUM_W'({mk, {FB{1'b0}}});
        dnum_next[1] = DNUM_W'({sqo.ays, {FB{1'b0}}});
        dnum_next[2] = DNUM_W'({sqo.axs, {FB{1'b0}}});
        dden_next[0] = DEN_W'(rhoc) + QUARTER;
        dden_next[1] = DEN_W'(sq_root);
        dden_next[2] = DEN_W'(sq_root);
        dv_side_next.pos   = sqo.pos;
        dv_side_next.pt    = sqo.pt;
        dv_side_next.swirl = sqo.swirl;
        dv_side_next.xneg  = sqo.xneg;
        dv_side_next.yneg  = sqo.yneg;
    end

    logic [2:0][DNUM_W-1:0] dnum5_reg;
    logic [2:0][DEN_W-1:0]  dden5_reg;
    dv_side_t               side5_reg;
    logic                   vld5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld5_reg <= 1'b0;
        end else if (adv) begin
            vld5_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dnum5_reg <= dnum_next;
            dden5_reg <= dden_next;
            side5_reg <= dv_side_next;
        end
    end

    // division: swirl gain, unit direction x and y
    logic                   dv_valid;
    logic [2:0][DIV_Q-1:0]  dv_quo;
    logic [DV_SIDE_W-1:0]   dv_side_raw;
    dv_side_t               dvo;

    afps_div_pipe #(
        .LANES  (3),
        .NUM_W  (DNUM_W),
        .DEN_W  (DEN_W),
        .Q_W    (DIV_Q),
        .SIDE_W (DV_SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vld5_reg),
        .in_num    (dnum5_reg),
        .in_den    (dden5_reg),
        .in_side   (side5_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side_raw)
    );

    assign dvo = dv_side_t'(dv_side_raw);

    // stage 6: apply signs
    logic signed [K_W-1:0] k_mag, k_next;
    logic signed [U_W-1:0] ux_mag, uy_mag, ux_next, uy_next;

    always_comb begin
        k_mag  = $signed({1'b0, dv_quo[0]});
        ux_mag = $signed({1'b0, dv_quo[1][FB:0]});
        uy_mag = $signed({1'b0, dv_quo[2][FB:0]});
        k_next  = az_reg[AZ_W-1] ? -k_mag : k_mag;
        ux_next = dvo.yneg ? ux_mag : -ux_mag;
        uy_next = dvo.xneg ? -uy_mag : uy_mag;
        if (!dvo.swirl) begin
            k_next = '0;
        end
    end

    logic signed [K_W-1:0] k6_reg;
    logic signed [U_W-1:0] ux6_reg, uy6_reg;
    dv_side_t              side6_reg;
    logic                  vld6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld6_reg <= 1'b0;
        end else if (adv) begin
            vld6_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            k6_reg    <= k_next;
            ux6_reg   <= ux_next;
            uy6_reg   <= uy_next;
            side6_reg <= dvo;
        end
    end

    // stage 7: swirl products
    logic signed [VP_W-1:0] vpx7_reg, vpy7_reg;
    dv_side_t               side7_reg;
    logic                   vld7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld7_reg <= 1'b0;
        end else if (adv) begin
            vld7_reg <= vld6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vpx7_reg  <= VP_W'(ux6_reg) * VP_W'(k6_reg);
            vpy7_reg  <= VP_W'(uy6_reg) * VP_W'(k6_reg);
            side7_reg <= side6_reg;
        end
    end

    // stage 8: velocity
    logic signed [V_W-1:0]  v_next [3];
    logic signed [VP_W-1:0] vp_adj;
    logic signed [VS_W-1:0] vs_x, vs_y;

    always_comb begin
        vp_adj = vpx7_reg + $signed({{(VP_W-FB){1'b0}}, {FB{vpx7_reg[VP_W-1]}}});
        vs_x = VS_W'(vp_adj >>> FB);
        vp_adj = vpy7_reg + $signed({{(VP_W-FB){1'b0}}, {FB{vpy7_reg[VP_W-1]}}});
        vs_y = VS_W'(vp_adj >>> FB);
        v_next[0] = V_W'(vs_x) + V_W'($signed(side7_reg.pt[0]));
        v_next[1] = V_W'(vs_y) + V_W'($signed(side7_reg.pt[1]));
        v_next[2] = V_W'($signed(side7_reg.pt[2]));
    end

    logic signed [V_W-1:0] v8_reg [3];
    afps_in_t              pos8_reg;
    logic                  vld8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld8_reg <= 1'b0;
        end else if (adv) begin
            vld8_reg <= vld7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            v8_reg   <= v_next;
            pos8_reg <= side7_reg.pos;
        end
    end

    // stage 9: displacement products
    logic signed [DP_W-1:0]  dp9_reg [3];
    logic signed [FRAME_W:0] dt_s;
    afps_in_t                pos9_reg;
    logic                    vld9_reg;

    assign dt_s = $signed({1'b0, frame_step_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld9_reg <= 1'b0;
        end else if (adv) begin
            vld9_reg <= vld8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                dp9_reg[i] <= DP_W'(v8_reg[i]) * DP_W'(dt_s);
            end
            pos9_reg <= pos8_reg;
        end
    end

    // stage 10: moved position and offset from home
    logic signed [CW-1:0]   p9 [3];
    logic signed [CW-1:0]   h9 [3];
    logic signed [DP_W-1:0] dp_adj;
    logic signed [DL_W-1:0] dl;
    logic signed [NP_W-1:0] np_next [3];
    logic signed [D_W-1:0]  d_next [3];

    assign p9[0] = pos9_reg.pos_x;
    assign p9[1] = pos9_reg.pos_y;
    assign p9[2] = pos9_reg.pos_z;
    assign h9[0] = pos9_reg.home_x;
    assign h9[1] = pos9_reg.home_y;
    assign h9[2] = pos9_reg.home_z;

    always_comb begin
        dp_adj = '0;
        dl = '0;
        for (int i = 0; i < 3; i++) begin
            dp_adj = dp9_reg[i] + $signed({{(DP_W-FB){1'b0}}, {FB{dp9_reg[i][DP_W-1]}}});
            dl = DL_W'(dp_adj >>> FB);
            np_next[i] = NP_W'(p9[i]) + NP_W'(dl);
            d_next[i] = D_W'(np_next[i]) - D_W'(h9[i]);
        end
    end

    logic signed [NP_W-1:0] np10_reg [3];
    logic signed [D_W-1:0]  d10_reg [3];
    afps_in_t               pos10_reg;
    logic                   vld10_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld10_reg <= 1'b0;
        end else if (adv) begin
            vld10_reg <= vld9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            np10_reg  <= np_next;
            d10_reg   <= d_next;
            pos10_reg <= pos9_reg;
        end
    end

    // stage 11: per-axis distance check and squares
    logic [D_W-1:0]   dabs;
    logic             big_next;
    logic [SQD_W-1:0] dsq_next [3];

    always_comb begin
        big_next = 1'b0;
        dabs = '0;
        for (int i = 0; i < 3; i++) begin
            dabs = d10_reg[i][D_W-1] ? D_W'(-d10_reg[i]) : D_W'(d10_reg[i]);
            if (dabs > D_W'(rdist_reg)) begin
                big_next = 1'b1;
            end
            dsq_next[i] = SQD_W'(dabs[RDIST_W-1:0]) * SQD_W'(dabs[RDIST_W-1:0]);
        end
    end

    logic [SQD_W-1:0]       dsq11_reg [3];
    logic [SQD_W-1:0]       rdsq11_reg;
    logic                   big11_reg;
    logic signed [NP_W-1:0] np11_reg [3];
    afps_in_t               pos11_reg;
    logic                   vld11_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld11_reg <= 1'b0;
        end else if (adv) begin
            vld11_reg <= vld10_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dsq11_reg  <= dsq_next;
            rdsq11_reg <= SQD_W'(rdist_reg) * SQD_W'(rdist_reg);
            big11_reg  <= big_next;
            np11_reg   <= np10_reg;
            pos11_reg  <= pos10_reg;
        end
    end

    // stage 12: respawn decision, saturate, output register
    logic [SUM_W-1:0]     dsum;
    logic                 far;
    logic signed [CW-1:0] sat [3];
    afps_out_t            out_next;

    always_comb begin
        dsum = SUM_W'(dsq11_reg[0]) + SUM_W'(dsq11_reg[1]) + SUM_W'(dsq11_reg[2]);
        far = big11_reg || (dsum > SUM_W'(rdsq11_reg));
        for (int i = 0; i < 3; i++) begin
            if (np11_reg[i] > NP_MAX) begin
                sat[i] = CW'(NP_MAX);
            end else if (np11_reg[i] < NP_MIN) begin
                sat[i] = CW'(NP_MIN);
            end else begin
                sat[i] = CW'(np11_reg[i]);
            end
        end
        out_next.new_x     = far ? pos11_reg.home_x : sat[0];
        out_next.new_y     = far ? pos11_reg.home_y : sat[1];
        out_next.new_z     = far ? pos11_reg.home_z : sat[2];
        out_next.respawned = far;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld11_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= out_next;
        end
    end

endmodule

@@ design/afps_checker.sv @@
// Port-level checks for azimuthal_flow_particle_step, bound to the top level.
// Uses afps_pkg for the payload types.
module afps_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input afps_pkg::afps_out_t             m_data,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);
    import afps_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("request ready does not follow output state");

    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("register write stalled");

endmodule

bind azimuthal_flow_particle_step afps_checker u_afps_checker (.*);
